### rtl/core/horizontal_motion_blur_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the horizontal motion blur unit
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef HORIZONTAL_MOTION_BLUR_UNIT_ASSERT_SVH
`define HORIZONTAL_MOTION_BLUR_UNIT_ASSERT_SVH

// property checked outside reset
`define HMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define HMB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/hmb_pkg.sv
// ----------------------------------------------------------------------------
// hmb_pkg
// Types and constants shared by the horizontal motion blur modules.
// ----------------------------------------------------------------------------
package hmb_pkg;

  localparam int ChanW      = 8;
  localparam int NumLanes   = 3;
  localparam int WordW      = ChanW * NumLanes;
  localparam int StoreDepth = 32;
  localparam int AddrW      = 5;
  localparam int CountW     = 6;
  localparam int LenW       = 5;
  localparam int SumW       = 13;
  localparam int NumW       = 14;
  localparam int DivSteps   = 8;
  localparam int StepW      = 3;

  localparam logic [LenW-1:0] BlurReset = 5'd1;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             row_end;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             row_last;
  } result_t;

  typedef logic [NumLanes-1:0][ChanW-1:0] chan_vec_t;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] n;
  } lane_op_t;

  typedef struct packed {
    logic load;
    logic row_last;
  } load_t;

endpackage

### rtl/core/horizontal_motion_blur_unit.sv
// ----------------------------------------------------------------------------
// horizontal_motion_blur_unit
// Forward-window motion blur over a raster RGB stream, three channel lanes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  pixel     in         pixel_valid / stall  pixel_t, one pixel
//  result    out        result_valid / stall result_t, one blurred pixel
//  cfg       in         cfg_valid / ready    blur amount, 5 bits
//
//  A pixel that releases no result leaves the block in IDLE; one that does adds a head read.
//  Each result takes a head fetch, an 8-step lane divide and a load; no divide when n is 0.
//  Surplus pixels left by a lowered blur amount add a walk over the window taps.
//  Synchronous reset; the window memory needs no clearing pass.
//  result_stall holds the output register; pixel_stall stays high while
//  results of an accepted pixel are in work.
// ----------------------------------------------------------------------------
module horizontal_motion_blur_unit #(
  parameter int MAX_BLUR = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  hmb_pkg::pixel_t           pixel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output hmb_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hmb_pkg::LenW-1:0]  cfg_data
);

  localparam int CapBlur = (MAX_BLUR < hmb_pkg::StoreDepth - 1) ? MAX_BLUR
                                                                : hmb_pkg::StoreDepth - 1;

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    READ = 5'b00010,
    PIX  = 5'b00100,
    WALK = 5'b01000,
    DIV  = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [hmb_pkg::LenW-1:0]      blur_amount;
  logic [hmb_pkg::LenW-1:0]      len;

  logic [hmb_pkg::WordW-1:0]     mem [hmb_pkg::StoreDepth];
  logic [hmb_pkg::AddrW-1:0]     rd_addr;
  logic [hmb_pkg::AddrW-1:0]     wr_addr;
  logic [hmb_pkg::WordW-1:0]     rd_data;
  logic [hmb_pkg::WordW-1:0]     in_word;

  logic [hmb_pkg::AddrW-1:0]     head;
  logic [hmb_pkg::CountW-1:0]    fill;
  logic [hmb_pkg::CountW-1:0]    emit_left;
  logic                          rend;
  logic [hmb_pkg::SumW-1:0]      sum [hmb_pkg::NumLanes];
  logic [hmb_pkg::SumW-1:0]      acc [hmb_pkg::NumLanes];
  hmb_pkg::chan_vec_t            pix;
  logic [hmb_pkg::AddrW-1:0]     walk_ptr;
  logic [hmb_pkg::LenW-1:0]      walk_left;

  logic                          acc_in;
  logic [hmb_pkg::CountW-1:0]    cnt;
  logic [hmb_pkg::CountW-1:0]    emit_cnt;
  logic                          fast;
  logic [hmb_pkg::LenW-1:0]      n_sel;

  hmb_pkg::chan_vec_t            rd_chan;
  hmb_pkg::chan_vec_t            in_chan;
  hmb_pkg::chan_vec_t            lane_p;
  hmb_pkg::chan_vec_t            lane_q;
  logic [hmb_pkg::SumW-1:0]      lane_s [hmb_pkg::NumLanes];
  logic [hmb_pkg::NumLanes-1:0]  lane_busy;
  hmb_pkg::lane_op_t             lane_op;
  hmb_pkg::load_t                merge_ctl;
  logic                          can_load;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = (state != IDLE);
  assign acc_in      = pixel_valid && !pixel_stall;
  assign len         = (int'(blur_amount) > CapBlur) ? hmb_pkg::LenW'(CapBlur) : blur_amount;

  assign in_word  = {pixel.red_in, pixel.green_in, pixel.blue_in};
  assign wr_addr  = head + fill[hmb_pkg::AddrW-1:0];
  assign cnt      = fill + hmb_pkg::CountW'(1);

  always_comb begin
    if (pixel.row_end) begin
      emit_cnt = cnt;
    end else if (cnt > hmb_pkg::CountW'(len)) begin
      emit_cnt = cnt - hmb_pkg::CountW'(len);
    end else begin
      emit_cnt = '0;
    end
  end

  assign fast  = (fill - hmb_pkg::CountW'(1)) <= hmb_pkg::CountW'(len);
  assign n_sel = fast ? hmb_pkg::LenW'(fill - hmb_pkg::CountW'(1)) : len;

  always_comb begin
    case (state)
      PIX:     rd_addr = head + hmb_pkg::AddrW'(1);
      WALK:    rd_addr = walk_ptr;
      DIV:     rd_addr = head + hmb_pkg::AddrW'(1);
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      mem[wr_addr] <= in_word;
    end
    rd_data <= mem[rd_addr];
  end

  assign lane_op.start = ((state == PIX) && (fast || (len == '0)))
                      || ((state == WALK) && (walk_left == hmb_pkg::LenW'(1)));
  assign lane_op.n     = (state == PIX) ? n_sel : len;

  assign merge_ctl.load     = (state == DIV) && (lane_busy == '0) && can_load;
  assign merge_ctl.row_last = rend && (emit_left == hmb_pkg::CountW'(1));

  for (genvar c = 0; c < hmb_pkg::NumLanes; c++) begin : g_lane
    assign rd_chan[c] = rd_data[(hmb_pkg::NumLanes-1-c)*hmb_pkg::ChanW +: hmb_pkg::ChanW];
    assign in_chan[c] = in_word[(hmb_pkg::NumLanes-1-c)*hmb_pkg::ChanW +: hmb_pkg::ChanW];
    assign lane_p[c]  = (state == PIX) ? rd_chan[c] : pix[c];

    always_comb begin
      if (state == WALK) begin
        lane_s[c] = acc[c] + hmb_pkg::SumW'(rd_chan[c]);
      end else if (fast) begin
        lane_s[c] = sum[c] - hmb_pkg::SumW'(rd_chan[c]);
      end else begin
        lane_s[c] = '0;
      end
    end

    hmb_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .op   (lane_op),
      .p    (lane_p[c]),
      .s    (lane_s[c]),
      .q    (lane_q[c]),
      .busy (lane_busy[c])
    );
  end

  hmb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (merge_ctl),
    .q            (lane_q),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .can_load     (can_load)
  );

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (acc_in && (emit_cnt != '0)) begin
          state_next = READ;
        end
      end
      READ: begin
        state_next = PIX;
      end
      PIX: begin
        state_next = (fast || (len == '0)) ? DIV : WALK;
      end
      WALK: begin
        if (walk_left == hmb_pkg::LenW'(1)) begin
          state_next = DIV;
        end
      end
      DIV: begin
        if (merge_ctl.load) begin
          state_next = (emit_left == hmb_pkg::CountW'(1)) ? IDLE : PIX;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_amount <= hmb_pkg::BlurReset;
    end else if (cfg_valid && cfg_ready) begin
      blur_amount <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      fill      <= '0;
      emit_left <= '0;
      for (int c = 0; c < hmb_pkg::NumLanes; c++) begin
        sum[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (acc_in) begin
        fill      <= cnt;
        emit_left <= emit_cnt;
        for (int c = 0; c < hmb_pkg::NumLanes; c++) begin
          sum[c] <= sum[c] + hmb_pkg::SumW'(in_chan[c]);
        end
      end else if (merge_ctl.load) begin
        head      <= head + hmb_pkg::AddrW'(1);
        fill      <= fill - hmb_pkg::CountW'(1);
        emit_left <= emit_left - hmb_pkg::CountW'(1);
        for (int c = 0; c < hmb_pkg::NumLanes; c++) begin
          sum[c] <= sum[c] - hmb_pkg::SumW'(pix[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      rend <= pixel.row_end;
    end
    case (state)
      PIX: begin
        pix       <= rd_chan;
        walk_ptr  <= head + hmb_pkg::AddrW'(2);
        walk_left <= len;
        for (int c = 0; c < hmb_pkg::NumLanes; c++) begin
          acc[c] <= '0;
        end
      end
      WALK: begin
        walk_ptr  <= walk_ptr + hmb_pkg::AddrW'(1);
        walk_left <= walk_left - hmb_pkg::LenW'(1);
        for (int c = 0; c < hmb_pkg::NumLanes; c++) begin
          acc[c] <= acc[c] + hmb_pkg::SumW'(rd_chan[c]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/hmb_lane.sv
// ----------------------------------------------------------------------------
// hmb_lane
// One channel lane: forms n*p + s and divides it by 2n, one quotient bit
// per cycle. n of zero passes p through.
// ----------------------------------------------------------------------------
module hmb_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  hmb_pkg::lane_op_t           op,
  input  logic [hmb_pkg::ChanW-1:0]   p,
  input  logic [hmb_pkg::SumW-1:0]    s,
  output logic [hmb_pkg::ChanW-1:0]   q,
  output logic                        busy
);

  logic [hmb_pkg::NumW-1:0]     rem;
  logic [hmb_pkg::LenW:0]       dvs;
  logic [hmb_pkg::StepW-1:0]    step;
  logic [hmb_pkg::NumW:0]       shifted;
  logic                         fits;

  assign shifted = (hmb_pkg::NumW + 1)'(dvs) << step;
  assign fits    = (hmb_pkg::NumW + 1)'(rem) >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (op.start) begin
      busy <= (op.n != '0);
    end else if (busy && (step == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.start) begin
      rem  <= hmb_pkg::NumW'(op.n) * hmb_pkg::NumW'(p) + hmb_pkg::NumW'(s);
      dvs  <= {op.n, 1'b0};
      step <= hmb_pkg::StepW'(hmb_pkg::DivSteps - 1);
      q    <= (op.n == '0) ? p : '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - shifted[hmb_pkg::NumW-1:0];
      end
      q[step] <= fits;
      step    <= step - hmb_pkg::StepW'(1);
    end
  end

endmodule

### rtl/core/hmb_merge.sv
// ----------------------------------------------------------------------------
// hmb_merge
// Joins the lane quotients into one result word and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module hmb_merge (
  input  logic               clk,
  input  logic               rst,
  input  hmb_pkg::load_t     ctl,
  input  hmb_pkg::chan_vec_t q,
  input  logic               result_stall,
  output logic               result_valid,
  output hmb_pkg::result_t   result,
  output logic               can_load
);

  assign can_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result.red_out   <= q[0];
      result.green_out <= q[1];
      result.blue_out  <= q[2];
      result.row_last  <= ctl.row_last;
    end
  end

endmodule

### rtl/core/hmb_checker.sv
// ----------------------------------------------------------------------------
// hmb_checker
// Port-level checks on the horizontal motion blur unit, bound to the top.
// ----------------------------------------------------------------------------
`include "horizontal_motion_blur_unit_assert.svh"

module hmb_checker (
  input logic             clk,
  input logic             rst,
  input logic             pixel_valid,
  input logic             pixel_stall,
  input hmb_pkg::pixel_t  pixel,
  input logic             result_valid,
  input logic             result_stall,
  input hmb_pkg::result_t result
);

  // reset leaves the block empty and open for pixels
  `HMB_ASSERT_RST(a_reset_empty, rst |=> !result_valid && !pixel_stall, "reset did not clear")

  `HMB_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid && $stable(result), "stalled word changed")

  // a row end always releases at least its own pixel
  `HMB_ASSERT(a_row_end_stalls, pixel_valid && !pixel_stall && pixel.row_end |=> pixel_stall, "row end not flushed")

  // no result can rise in the cycle after a pixel is taken
  `HMB_ASSERT(a_no_early_result, pixel_valid && !pixel_stall |=> !$rose(result_valid), "result too early")

endmodule

bind horizontal_motion_blur_unit hmb_checker u_hmb_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### sim/horizontal_motion_blur_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// horizontal_motion_blur_unit_tb
// Self-checking bench for the forward-window motion blur. A directed run
// covers pass-through, the widest window, lowered and raised amounts mid-row
// and short rows; random rows with random amount changes follow under four
// idle/stall mixes. Every result word is checked against a predicted window.
// ----------------------------------------------------------------------------
module horizontal_motion_blur_unit_tb;
  import hmb_pkg::*;

  localparam int BlurCap      = 31;
  localparam int SettleCycles = 40;
  localparam int CycleLimit   = 400000;
  localparam int PhaseWords   = 125;

  class blur_board;
    logic [WordW-1:0] held [StoreDepth];
    int unsigned      held_count;
    int unsigned      amount;
    result_t          blurred_due[$];
    int               errors;

    function new();
      held_count = 0;
      amount     = BlurReset;
      errors     = 0;
    endfunction

    function void set_amount(logic [LenW-1:0] v);
      amount = v;
    endfunction

    function logic [ChanW-1:0] blur_channel(int unsigned p, int unsigned s, int unsigned n);
      int unsigned q;
      if (n == 0) begin
        q = p;
      end else begin
        q = (n * p + s) / (2 * n);
      end
      return q[ChanW-1:0];
    endfunction

    function void take_pixel(pixel_t px);
      int unsigned span, cnt, emit, rest, n, sr, sg, sb;
      logic [WordW-1:0] q, w;
      result_t r;
      span = amount;
      if (span > BlurCap) span = BlurCap;
      if (span > StoreDepth - 1) span = StoreDepth - 1;
      if (held_count > StoreDepth - 1) held_count = StoreDepth - 1;
      held[held_count] = {px.red_in, px.green_in, px.blue_in};
      cnt = held_count + 1;
      if (px.row_end) begin
        emit = cnt;
      end else begin
        emit = (cnt > span) ? cnt - span : 0;
      end
      for (int j = 0; j < emit; j++) begin
        rest = cnt - 1 - j;
        n = (rest < span) ? rest : span;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int k = 1; k <= n; k++) begin
          q = held[(j + k) % StoreDepth];
          sr += q[23:16];
          sg += q[15:8];
          sb += q[7:0];
        end
        w = held[j];
        r.red_out   = blur_channel(w[23:16], sr, n);
        r.green_out = blur_channel(w[15:8], sg, n);
        r.blue_out  = blur_channel(w[7:0], sb, n);
        r.row_last  = px.row_end && (j == cnt - 1);
        blurred_due.push_back(r);
      end
      for (int i = 0; i < cnt - emit; i++) held[i] = held[i + emit];
      held_count = cnt - emit;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (blurred_due.size() == 0) begin
        $error("result word %h with none expected", got);
        errors++;
        return;
      end
      want = blurred_due.pop_front();
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
        errors++;
      end
      if (got.row_last !== want.row_last) begin
        $error("row_last: expected %0d, got %0d", want.row_last, got.row_last);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst          = 1'b1;
  logic            pixel_valid  = 1'b0;
  logic            pixel_stall;
  pixel_t          pixel        = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  result_t         result;
  logic            cfg_valid    = 1'b0;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data     = '0;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned cycles        = 0;
  blur_board   board         = new();

  horizontal_motion_blur_unit #(
    .MAX_BLUR(BlurCap)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("horizontal_motion_blur_unit_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_result(result);
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [ChanW-1:0] pick_chan();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t make_pixel(logic last);
    pixel_t p;
    p.red_in   = pick_chan();
    p.green_in = pick_chan();
    p.blue_in  = pick_chan();
    p.row_end  = last;
    return p;
  endfunction

  function automatic pixel_t rgb(int r, int g, int b, logic last);
    pixel_t p;
    p.red_in   = ChanW'(r);
    p.green_in = ChanW'(g);
    p.blue_in  = ChanW'(b);
    p.row_end  = last;
    return p;
  endfunction

  function automatic logic [LenW-1:0] pick_amount();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return LenW'(1);
      default: return LenW'($urandom_range(31));
    endcase
  endfunction

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    board.take_pixel(p);
  endtask

  // quiet point: no result owed, block back to idle
  task automatic settle();
    pixel_valid <= 1'b0;
    while (board.blurred_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_amount(logic [LenW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_amount(v);
  endtask

  task automatic run_phase(int idle, int stall, int words);
    int  left, len;
    logic last;
    send_idle_pct = idle;
    stall_pct     = stall;
    left          = words;
    while (left > 0) begin
      if ($urandom_range(99) < 35) begin
        settle();
        write_amount(pick_amount());
      end
      len  = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 20);
      last = ($urandom_range(99) < 60);
      for (int i = 0; i < len; i++) send_pixel(make_pixel(last && (i == len - 1)));
      left -= len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through
    write_amount(LenW'(0));
    send_pixel(rgb(0, 0, 0, 0));
    send_pixel(rgb(255, 255, 255, 0));
    send_pixel(rgb(18, 200, 7, 1));
    // widest window, row end shrinks n
    settle();
    write_amount('1);
    send_pixel(rgb(255, 255, 255, 0));
    send_pixel(rgb(0, 0, 0, 0));
    send_pixel(rgb(255, 0, 255, 0));
    send_pixel(rgb(0, 255, 0, 0));
    send_pixel(rgb(255, 255, 255, 1));
    send_pixel(rgb(90, 91, 92, 1));
    // amount lowered mid-row
    settle();
    write_amount(LenW'(4));
    for (int i = 0; i < 6; i++) send_pixel(make_pixel(1'b0));
    settle();
    write_amount(LenW'(1));
    send_pixel(make_pixel(1'b0));
    // amount raised mid-row
    settle();
    write_amount(LenW'(6));
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b0));
    send_pixel(make_pixel(1'b1));
    // reset-value amount, two-pixel row
    settle();
    write_amount(BlurReset);
    send_pixel(rgb(255, 0, 1, 0));
    send_pixel(rgb(254, 255, 0, 1));

    run_phase(0, 0, PhaseWords);
    run_phase(49, 0, PhaseWords);
    run_phase(0, 49, PhaseWords);
    run_phase(33, 33, PhaseWords);

    // close any open row so every pixel is flushed
    send_pixel(make_pixel(1'b1));
    settle();

    if (board.errors == 0 && board.blurred_due.size() == 0) begin
      $display("horizontal_motion_blur_unit_tb: clean");
    end else begin
      $display("horizontal_motion_blur_unit_tb: errors");
    end
    $finish;
  end

endmodule
